[rtl/joystick_axis_calibrated_map_unit_assert.svh]
// Assertion macros for the joystick axis map unit checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef JOYSTICK_AXIS_CALIBRATED_MAP_UNIT_ASSERT_SVH
`define JOYSTICK_AXIS_CALIBRATED_MAP_UNIT_ASSERT_SVH

`define JACM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define JACM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jacm_pkg.sv]
// Shared widths, limits and register indexes of the joystick axis map unit.
// No dependencies; used by the top level and its checker.
package jacm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned DEG_W  = 8;
  localparam int unsigned YAW_W  = 9;
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + 7;
  localparam int unsigned NUM_W  = PROD_W - 1;
  localparam int unsigned DEN_W  = SAMPLE_BITS + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned IN_FIELDS_W  = 2 * SAMPLE_BITS + 1;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 * DEG_W + YAW_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int DEG_LIMIT    = 90;
  localparam int HEADING_STEP = 15;
  localparam int HEADING_WRAP = 360;
  localparam int HEADING_MAX  = HEADING_WRAP - HEADING_STEP;

  localparam logic [SAMPLE_BITS-1:0] LOW_RST    = '0;
  localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST   = SAMPLE_BITS'(4095);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW    = 3'd0,
    REG_X_CENTER = 3'd1,
    REG_X_HIGH   = 3'd2,
    REG_Y_LOW    = 3'd3,
    REG_Y_CENTER = 3'd4,
    REG_Y_HIGH   = 3'd5
  } cfg_reg_e;

endpackage

[rtl/joystick_axis_calibrated_map_unit.sv]
// Joystick axis map unit: piecewise linear map of two axes around a calibrated
// center, plus a button-stepped heading. Depends on jacm_pkg.
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid / s_axis_tready  x_sample, y_sample, button_level
//   m_axis   out  m_axis_tvalid / m_axis_tready  roll, pitch, yaw
//   cfg      in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each item runs the accept, then per axis a setup state, the shared restoring
// divider (one quotient bit per divide step) and a finish state; the finish of
// the y axis loads roll, pitch and yaw into the output register.
// A new item is taken while the last result waits in the output register; a
// full output register holds the finish of the next item.
// Reset loads the calibration defaults and clears heading and button history.
// Config writes are taken every cycle.
module joystick_axis_calibrated_map_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // x_sample, y_sample, button_level
  input  logic [jacm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // roll, pitch, yaw
  output logic [jacm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jacm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jacm_pkg::SAMPLE_BITS-1:0] cfg_data_i
);
  import jacm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                   state_q;
  logic                     axis_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [SAMPLE_BITS-1:0]   x_samp_q, y_samp_q;
  logic [SAMPLE_BITS-1:0]   x_low_q, x_center_q, x_high_q;
  logic [SAMPLE_BITS-1:0]   y_low_q, y_center_q, y_high_q;
  logic                     prev_btn_q;
  logic [YAW_W-1:0]         heading_q;
  logic [NUM_W-1:0]         num_q;
  logic [DEN_W-1:0]         rem_q, den_q;
  logic                     qneg_q, zero_q, lower_q;
  logic signed [DEG_W-1:0]  roll_q;
  logic                     out_valid_q;
  logic signed [DEG_W-1:0]  out_roll_q, out_pitch_q;
  logic [YAW_W-1:0]         out_yaw_q;

  logic                     in_fire;
  logic [SAMPLE_BITS-1:0]   in_x, in_y;
  logic                     in_btn;
  logic [YAW_W-1:0]         heading_step, heading_d;

  logic [SAMPLE_BITS-1:0]   samp, lo, ctr, hi;
  logic                     lower;
  logic signed [DIFF_W-1:0] diff_lo, den_lo, diff_hi, den_hi, diff, den;
  logic signed [PROD_W-1:0] prod;
  logic [NUM_W-1:0]         num_mag;
  logic [DEN_W-1:0]         den_mag;

  logic [DEN_W:0]           rem_sh;
  logic                     ge;
  logic [DEN_W-1:0]         rem_d;

  logic signed [PROD_W-1:0] q_ext, q_s;
  logic signed [SUM_W-1:0]  sum, base;
  logic signed [DEG_W-1:0]  mapped;
  logic                     out_free;
  logic                     out_load;

  localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(DEG_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_NEG = -SUM_W'(DEG_LIMIT);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_x          = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_y          = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_btn        = s_axis_tdata[2*SAMPLE_BITS];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                          out_yaw_q, out_pitch_q, out_roll_q};
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_FIN) && axis_q && out_free;

  // heading advance on a falling button edge
  always_comb begin
    heading_step = heading_q + YAW_W'(HEADING_STEP);
    heading_d    = heading_q;
    if (prev_btn_q && !in_btn) begin
      heading_d = (heading_step >= YAW_W'(HEADING_WRAP)) ?
                  heading_step - YAW_W'(HEADING_WRAP) : heading_step;
    end
  end

  // segment select, numerator and divisor of the current axis
  always_comb begin
    samp    = axis_q ? y_samp_q   : x_samp_q;
    lo      = axis_q ? y_low_q    : x_low_q;
    ctr     = axis_q ? y_center_q : x_center_q;
    hi      = axis_q ? y_high_q   : x_high_q;
    lower   = (samp <= ctr);
    diff_lo = $signed({1'b0, samp}) - $signed({1'b0, lo});
    den_lo  = $signed({1'b0, ctr})  - $signed({1'b0, lo});
    diff_hi = $signed({1'b0, samp}) - $signed({1'b0, ctr}) - DIFF_W'(1);
    den_hi  = $signed({1'b0, hi})   - $signed({1'b0, ctr}) - DIFF_W'(1);
    diff    = lower ? diff_lo : diff_hi;
    den     = lower ? den_lo  : den_hi;
    prod    = PROD_W'(diff) * PROD_W'(DEG_LIMIT);
    num_mag = prod[PROD_W-1] ? NUM_W'(-prod) : NUM_W'(prod);
    den_mag = den[DIFF_W-1]  ? DEN_W'(-den)  : DEN_W'(den);
  end

  // one restoring divide step
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_d  = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
  end

  // sign, offset and clamp
  always_comb begin
    q_ext = $signed({1'b0, num_q});
    q_s   = qneg_q ? -q_ext : q_ext;
    base  = lower_q ? LIM_NEG : '0;
    sum   = SUM_W'(q_s) + base;
    priority if (zero_q) begin
      mapped = '0;
    end else if (sum > LIM_POS) begin
      mapped = DEG_W'(LIM_POS);
    end else if (sum < LIM_NEG) begin
      mapped = DEG_W'(LIM_NEG);
    end else begin
      mapped = DEG_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q    <= LOW_RST;
      x_center_q <= CENTER_RST;
      x_high_q   <= HIGH_RST;
      y_low_q    <= LOW_RST;
      y_center_q <= CENTER_RST;
      y_high_q   <= HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_LOW:    x_low_q    <= cfg_data_i;
        REG_X_CENTER: x_center_q <= cfg_data_i;
        REG_X_HIGH:   x_high_q   <= cfg_data_i;
        REG_Y_LOW:    y_low_q    <= cfg_data_i;
        REG_Y_CENTER: y_center_q <= cfg_data_i;
        REG_Y_HIGH:   y_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      prev_btn_q  <= 1'b0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
      out_roll_q  <= '0;
      out_pitch_q <= '0;
      out_yaw_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            prev_btn_q <= in_btn;
            heading_q  <= heading_d;
            axis_q     <= 1'b0;
            state_q    <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cnt_q   <= CNT_W'(NUM_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_SETUP;
          end else if (out_free) begin
            out_roll_q  <= roll_q;
            out_pitch_q <= mapped;
            out_yaw_q   <= heading_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_samp_q <= in_x;
      y_samp_q <= in_y;
    end
    if (state_q == ST_SETUP) begin
      num_q   <= num_mag;
      den_q   <= den_mag;
      rem_q   <= '0;
      qneg_q  <= prod[PROD_W-1] ^ den[DIFF_W-1];
      zero_q  <= (den == '0);
      lower_q <= lower;
    end else if (state_q == ST_DIV) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
    if (state_q == ST_FIN && !axis_q) begin
      roll_q <= mapped;
    end
  end

endmodule

[rtl/jacm_checker.sv]
// Port-level checker for the joystick axis map unit, bound to the top level.
// Depends on jacm_pkg and joystick_axis_calibrated_map_unit_assert.svh.
`include "joystick_axis_calibrated_map_unit_assert.svh"

module jacm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jacm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import jacm_pkg::*;

  localparam logic signed [DEG_W-1:0] LIM = DEG_W'(DEG_LIMIT);

  logic signed [DEG_W-1:0] roll_w, pitch_w;
  logic [YAW_W-1:0]        yaw_w;
  logic                    in_fire, out_stall;

  assign roll_w    = m_axis_tdata[DEG_W-1:0];
  assign pitch_w   = m_axis_tdata[2*DEG_W-1:DEG_W];
  assign yaw_w     = m_axis_tdata[2*DEG_W+YAW_W-1:2*DEG_W];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  `JACM_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready right after accept")
  `JACM_ASSERT_NOW(a_angle_range, m_axis_tvalid, (roll_w <= LIM) && (roll_w >= -LIM) && (pitch_w <= LIM) && (pitch_w >= -LIM), "angle out of range")
  `JACM_ASSERT_NOW(a_yaw_range, m_axis_tvalid, yaw_w <= YAW_W'(HEADING_MAX), "heading out of range")
  `JACM_ASSERT_NEXT(a_out_hold_valid, out_stall, m_axis_tvalid, "valid dropped while stalled")
  `JACM_ASSERT_NEXT(a_out_hold_data, out_stall, $stable(m_axis_tdata), "data changed while stalled")

endmodule

bind joystick_axis_calibrated_map_unit jacm_checker u_jacm_checker (.*);

[tb/joystick_axis_calibrated_map_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the joystick axis map unit: drives sample items and
// calibration writes, predicts roll, pitch and yaw, and checks every result.
// Depends on jacm_pkg and the joystick_axis_calibrated_map_unit RTL.
module joystick_axis_calibrated_map_unit_tb;
  import jacm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [SAMPLE_BITS-1:0] RAW_MAX = SAMPLE_BITS'((1 << SAMPLE_BITS) - 1);
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_REGS     = 6;

  typedef struct {
    logic signed [DEG_W-1:0] roll;
    logic signed [DEG_W-1:0] pitch;
    logic [YAW_W-1:0]        yaw;
  } attitude_t;

  class attitude_scoreboard;
    logic [SAMPLE_BITS-1:0] cal [NUM_REGS];
    logic                   prev_button;
    logic [YAW_W-1:0]       heading;
    attitude_t              expected_q [$];
    int                     mismatches;
    int                     checked;
    int                     edges;

    function new();
      cal[REG_X_LOW]    = LOW_RST;
      cal[REG_X_CENTER] = CENTER_RST;
      cal[REG_X_HIGH]   = HIGH_RST;
      cal[REG_Y_LOW]    = LOW_RST;
      cal[REG_Y_CENTER] = CENTER_RST;
      cal[REG_Y_HIGH]   = HIGH_RST;
      prev_button = 1'b0;
      heading     = '0;
      mismatches  = 0;
      checked     = 0;
      edges       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_BITS-1:0] val);
      if (idx <= REG_Y_HIGH) begin
        cal[idx] = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic signed [DEG_W-1:0] map_deflection(logic [SAMPLE_BITS-1:0] s, lo, c, hi);
      longint num;
      longint den;
      longint base;
      longint r;
      if (s <= c) begin
        num  = (longint'(s) - longint'(lo)) * DEG_LIMIT;
        den  = longint'(c) - longint'(lo);
        base = -DEG_LIMIT;
      end else begin
        num  = (longint'(s) - longint'(c) - 1) * DEG_LIMIT;
        den  = longint'(hi) - longint'(c) - 1;
        base = 0;
      end
      r = (den == 0) ? 0 : num / den + base;
      if (r > DEG_LIMIT) r = DEG_LIMIT;
      if (r < -DEG_LIMIT) r = -DEG_LIMIT;
      return r[DEG_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] x, y, logic btn);
      attitude_t a;
      int        h;
      if (prev_button && !btn) begin
        edges++;
        h = int'(heading) + HEADING_STEP;
        if (h >= HEADING_WRAP) h -= HEADING_WRAP;
        heading = YAW_W'(h);
      end
      prev_button = btn;
      a.roll  = map_deflection(x, cal[REG_X_LOW], cal[REG_X_CENTER], cal[REG_X_HIGH]);
      a.pitch = map_deflection(y, cal[REG_Y_LOW], cal[REG_Y_CENTER], cal[REG_Y_HIGH]);
      a.yaw   = heading;
      expected_q.push_back(a);
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
    endtask

    task check_attitude(logic [OUT_TDATA_W-1:0] d);
      attitude_t a;
      attitude_t want;
      a.roll  = d[DEG_W-1:0];
      a.pitch = d[2*DEG_W-1:DEG_W];
      a.yaw   = d[2*DEG_W+YAW_W-1:2*DEG_W];
      if (expected_q.size() == 0) begin
        report("result with nothing pending", int'(d), 0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (a.roll !== want.roll) report("roll", int'(a.roll), int'(want.roll));
        if (a.pitch !== want.pitch) report("pitch", int'(a.pitch), int'(want.pitch));
        if (a.yaw !== want.yaw) report("yaw", int'(a.yaw), int'(want.yaw));
      end
    endtask
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [SAMPLE_BITS-1:0] cfg_data_i    = '0;

  attitude_scoreboard sb = new();
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int items_sent         = 0;
  int settings_used      = 0;

  joystick_axis_calibrated_map_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_attitude(m_axis_tdata);
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, y, input logic btn);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({btn, y, x});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(x, y, btn);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // spare indexes go last so that any aliasing onto a real register shows
  task automatic calibrate(input logic [SAMPLE_BITS-1:0] xl, xc, xh, yl, yc, yh);
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_CENTER, xc);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_CENTER, yc);
    write_reg(REG_Y_HIGH, yh);
    write_reg(REG_SPARE_LO, SAMPLE_BITS'($urandom));
    write_reg(REG_SPARE_HI, RAW_MAX);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return RAW_MAX;
      default: return SAMPLE_BITS'($urandom_range(int'(RAW_MAX)));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] near(logic [SAMPLE_BITS-1:0] v);
    int w;
    w = int'(v) + int'($urandom_range(6)) - 3;
    if (w < 0) w = 0;
    if (w > int'(RAW_MAX)) w = int'(RAW_MAX);
    return SAMPLE_BITS'(w);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] lo, c, hi);
    case ($urandom_range(9))
      0: return '0;
      1: return RAW_MAX;
      2, 3: return near(c);
      4: return near(lo);
      5: return near(hi);
      default: return SAMPLE_BITS'($urandom_range(int'(RAW_MAX)));
    endcase
  endfunction

  task automatic random_calibration();
    logic [SAMPLE_BITS-1:0] v [NUM_REGS];
    logic [SAMPLE_BITS-1:0] t;
    for (int i = 0; i < NUM_REGS; i++) v[i] = pick_level();
    for (int a = 0; a < NUM_REGS; a += 3) begin
      if ($urandom_range(3) != 0) begin
        if (v[a] > v[a+1]) begin t = v[a]; v[a] = v[a+1]; v[a+1] = t; end
        if (v[a+1] > v[a+2]) begin t = v[a+1]; v[a+1] = v[a+2]; v[a+2] = t; end
        if (v[a] > v[a+1]) begin t = v[a]; v[a] = v[a+1]; v[a+1] = t; end
      end
      if ($urandom_range(5) == 0) v[a+1] = v[a];
      if ($urandom_range(5) == 0 && v[a+1] != RAW_MAX) v[a+2] = v[a+1] + 1'b1;
    end
    calibrate(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic random_phase(input int idle, input int stall, input int count);
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    random_calibration();
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      x = pick_sample(sb.cal[REG_X_LOW], sb.cal[REG_X_CENTER], sb.cal[REG_X_HIGH]);
      y = pick_sample(sb.cal[REG_Y_LOW], sb.cal[REG_Y_CENTER], sb.cal[REG_Y_HIGH]);
      send_sample(x, y, 1'($urandom_range(1)));
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(12'd0, 12'd0, 1'b0);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_sample(12'd2048, 12'd2048, 1'b0);
    send_sample(12'd2049, 12'd2047, 1'b0);
    send_sample(12'd1024, 12'd3072, 1'b1);
    send_sample(12'd4095, 12'd0, 1'b0);
    send_sample(12'd1, 12'd4094, 1'b1);
    send_sample(12'd2048, 12'd2049, 1'b0);
    drain();

    // both x segments have zero span; no y sample can reach the y upper segment
    calibrate(12'd100, 12'd100, 12'd101, 12'd0, 12'd4095, 12'd0);
    send_sample(12'd100, 12'd0, 1'b1);
    send_sample(12'd101, 12'd4095, 1'b0);
    send_sample(12'd102, 12'd2000, 1'b1);
    send_sample(12'd99, 12'd1, 1'b0);
    send_sample(12'd4095, 12'd0, 1'b1);
    drain();

    calibrate(12'd3000, 12'd1000, 12'd500, 12'd4095, 12'd0, 12'd4095);
    send_sample(12'd0, 12'd0, 1'b0);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_sample(12'd1000, 12'd1, 1'b0);
    send_sample(12'd1001, 12'd0, 1'b1);
    send_sample(12'd600, 12'd2048, 1'b0);
    drain();

    calibrate(12'd1500, 12'd2000, 12'd2500, 12'd1000, 12'd1100, 12'd1200);
    send_sample(12'd0, 12'd4095, 1'b1);
    send_sample(12'd4095, 12'd0, 1'b0);
    send_sample(12'd1500, 12'd1000, 1'b1);
    send_sample(12'd2500, 12'd1200, 1'b0);
    send_sample(12'd2001, 12'd1101, 1'b1);
    drain();

    random_phase(0, 0, 120);
    random_phase(51, 0, 120);
    random_phase(0, 51, 120);
    random_phase(18, 18, 120);

    if (sb.pending() != 0) sb.report("results never delivered", 0, sb.pending());
    $display("Sent %0d items across %0d calibration settings, %0d button presses.",
             items_sent, settings_used + 1, sb.edges);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/jacm_pkg.sv
rtl/joystick_axis_calibrated_map_unit.sv
rtl/jacm_checker.sv
tb/joystick_axis_calibrated_map_unit_tb.sv
